[src/lzg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_pkg
// Types and constants shared by the gamma LZ decompressor files.
// ----------------------------------------------------------------------------
package lzg_pkg;

  localparam int unsigned WindowSize = 65536;
  localparam int unsigned AddrW      = $clog2(WindowSize);
  localparam int unsigned FillW      = AddrW + 1;

  localparam logic [31:0] ThreshHi = 32'd32000;
  localparam logic [31:0] ThreshMid = 32'd1280;
  localparam logic [31:0] ThreshLo = 32'd128;
  localparam logic [31:0] NoOffset = 32'hFFFF_FFFF;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRejected = 3'd1;
  localparam logic [2:0] StBadOff   = 3'd2;
  localparam logic [2:0] StNoPrev   = 3'd3;
  localparam logic [2:0] StGammaOvf = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } lzg_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        byte_taken;
    logic        need_byte;
    logic        stream_done;
    logic [2:0]  status;
    logic [31:0] bytes_out_total;
  } lzg_rsp_t;

endpackage

[src/lzg_hist_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_hist_ram
// History window: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzg_hist_ram import lzg_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [WindowSize];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/lz_gamma_stream_decompressor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_gamma_stream_decompressor_unit
// Streaming gamma-coded LZ decompressor with a 64 KiB history window.
// ----------------------------------------------------------------------------
// A push request places one compressed byte in a one-byte holding register
// unless that register is already full, in which case it is rejected. A
// tick request runs a small sequencer that consumes tag bits and bytes one
// decode step at a time until an output byte is made, a byte is missing, or
// the stream ends; a copy from the window goes through the registered
// history-memory read. The request side is stalled while a request is in
// work and until its response has been taken. Errors (bad offset, repeat
// without a previous offset, gamma value above 32 bits) are sticky and stop
// decoding.
module lz_gamma_stream_decompressor_unit import lzg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lzg_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lzg_rsp_t out_data_o
);

  typedef enum logic [16:0] {
    PhFirst = 17'h00001, PhTag1 = 17'h00002, PhLit  = 17'h00004,
    PhTag2  = 17'h00008, PhTag3 = 17'h00010, PhNib  = 17'h00020,
    PhShort = 17'h00040, PhGov  = 17'h00080, PhGoc  = 17'h00100,
    PhOfflo = 17'h00200, PhGlv  = 17'h00400, PhGlc  = 17'h00800,
    PhCopy  = 17'h01000, PhDone = 17'h02000, PhRead = 17'h04000,
    PhGlen  = 17'h08000, PhErr  = 17'h10000
  } phase_e;

  typedef enum logic [2:0] {
    SIdle = 3'b001, SRun = 3'b010, SResp = 3'b100
  } seq_e;

  seq_e            seq_q, seq_d;
  phase_e          ph_q, ph_d, ret_q, ret_d;
  logic [7:0]      hold_q, hold_d, tag_q, tag_d;
  logic            hfull_q, hfull_d, am_q, am_d, done_q, done_d, err_q, err_d;
  logic [3:0]      tleft_q, tleft_d;
  logic [31:0]     lastoff_q, lastoff_d, gacc_q, gacc_d, moff_q, moff_d;
  logic [31:0]     copy_q, copy_d, cnt_q, cnt_d;
  logic [2:0]      ecode_q, ecode_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] wpos_q, wpos_d;
  lzg_rsp_t        rsp_q, rsp_d;

  logic            we;
  logic [7:0]      wdata, rdata;
  logic [AddrW-1:0] raddr;

  lzg_hist_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(wpos_q), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = (seq_q != SIdle);
  assign out_valid_o = (seq_q == SResp);
  assign out_data_o  = rsp_q;
  assign raddr = wpos_q - moff_q[AddrW-1:0];

  // bit fetch helpers
  logic       bit_ok, bitv;
  logic [7:0] tag_n;
  logic       hf_b;
  logic [3:0] tl_n;
  logic [32:0] off_full;
  logic [33:0] len_x;

  always_comb begin
    bit_ok = 1'b1; hf_b = hfull_q;
    if (tleft_q == 4'd0) begin
      bit_ok = hfull_q; hf_b = 1'b0;
      bitv = hold_q[7]; tag_n = {hold_q[6:0], 1'b0}; tl_n = 4'd7;
    end else begin
      bitv = tag_q[7]; tag_n = {tag_q[6:0], 1'b0}; tl_n = tleft_q - 4'd1;
    end
    off_full = {1'b0, moff_q[23:0], hold_q};
    len_x = {2'b0, gacc_q};
    if (am_q) begin
      len_x = len_x + ((moff_q >= ThreshHi) ? 34'd1 : 34'd0)
                    + ((moff_q >= ThreshMid) ? 34'd1 : 34'd0)
                    + ((moff_q < ThreshLo) ? 34'd2 : 34'd0);
    end
  end

  // response builder for the finishing cycle
  function automatic lzg_rsp_t mk(logic v, logic [7:0] b, logic nb, logic dn,
                                  logic [2:0] st, logic [31:0] c);
    lzg_rsp_t r;
    r.out_valid = v; r.out_byte = b; r.byte_taken = 1'b0; r.need_byte = nb;
    r.stream_done = dn; r.status = st; r.bytes_out_total = c;
    return r;
  endfunction

  always_comb begin
    seq_d = seq_q; ph_d = ph_q; ret_d = ret_q; hold_d = hold_q; tag_d = tag_q;
    hfull_d = hfull_q; am_d = am_q; done_d = done_q; err_d = err_q;
    tleft_d = tleft_q; lastoff_d = lastoff_q; gacc_d = gacc_q; moff_d = moff_q;
    copy_d = copy_q; cnt_d = cnt_q; ecode_d = ecode_q; fill_d = fill_q;
    wpos_d = wpos_q; rsp_d = rsp_q; we = 1'b0; wdata = 8'd0;
    unique case (seq_q)
      SIdle: begin
        if (in_valid_i) begin
          if (!in_data_i.req_type) begin
            rsp_d = mk(1'b0, 8'd0, 1'b0, done_q, StOk, cnt_q);
            if (hfull_q) begin
              rsp_d.status = StRejected;
            end else begin
              hold_d = in_data_i.in_byte; hfull_d = 1'b1;
              rsp_d.byte_taken = 1'b1;
              rsp_d.status = err_q ? ecode_q : StOk;
            end
            seq_d = SResp;
          end else if (err_q || done_q) begin
            rsp_d = mk(1'b0, 8'd0, 1'b0, done_q, err_q ? ecode_q : StOk, cnt_q);
            seq_d = SResp;
          end else begin
            seq_d = SRun;
          end
        end
      end
      SRun: begin
        unique case (ph_q)
          PhFirst, PhLit: begin
            if (!hfull_q) begin
              rsp_d = mk(1'b0, 8'd0, 1'b1, 1'b0, StOk, cnt_q); seq_d = SResp;
            end else begin
              hfull_d = 1'b0; we = 1'b1; wdata = hold_q;
              if (ph_q == PhLit) am_d = 1'b0;
              ph_d = PhTag1;
            end
          end
          PhTag1, PhTag2, PhTag3, PhNib, PhGov, PhGlv, PhGoc, PhGlc: begin
            if (!bit_ok) begin
              rsp_d = mk(1'b0, 8'd0, 1'b1, 1'b0, StOk, cnt_q); seq_d = SResp;
            end else begin
              hfull_d = hf_b; tag_d = tag_n; tleft_d = tl_n;
              unique case (ph_q)
                PhTag1: ph_d = bitv ? PhTag2 : PhLit;
                PhTag2: begin
                  if (bitv) ph_d = PhTag3;
                  else begin gacc_d = 32'd1; ph_d = PhGov; end
                end
                PhTag3: begin
                  if (bitv) begin moff_d = 32'd0; copy_d = 32'd4; ph_d = PhNib; end
                  else ph_d = PhShort;
                end
                PhNib: begin
                  moff_d = {28'd0, moff_q[2:0], bitv};
                  copy_d = copy_q - 32'd1;
                  if (copy_q == 32'd1) begin
                    am_d = 1'b0;
                    if ({moff_q[2:0], bitv} == 4'd0) begin
                      we = 1'b1; wdata = 8'd0; ph_d = PhTag1;
                    end else if ({1'b0, moff_q[2:0], bitv} > fill_q[4:0]
                                 && fill_q < FillW'(16)) begin
                      ph_d = PhErr; ecode_d = StBadOff;
                    end else begin
                      copy_d = 32'd1; ret_d = PhTag1; ph_d = PhRead;
                    end
                  end
                end
                PhGov, PhGlv: begin
                  if (gacc_q[31]) begin
                    ph_d = PhErr; ecode_d = StGammaOvf;
                  end else begin
                    gacc_d = {gacc_q[30:0], bitv};
                    ph_d = (ph_q == PhGov) ? PhGoc : PhGlc;
                  end
                end
                PhGoc: begin
                  if (bitv) ph_d = PhGov;
                  else if (!am_q && gacc_q == 32'd2) begin
                    if (lastoff_q == NoOffset) begin
                      ph_d = PhErr; ecode_d = StNoPrev;
                    end else begin
                      moff_d = lastoff_q; gacc_d = 32'd1; ph_d = PhGlv;
                    end
                  end else begin
                    moff_d = gacc_q - (am_q ? 32'd2 : 32'd3);
                    am_d = 1'b1; ph_d = PhOfflo;
                  end
                end
                default: begin
                  if (bitv) ph_d = PhGlv;
                  else ph_d = PhGlen;
                end
              endcase
            end
          end
          PhGlen: begin
            am_d = 1'b1;
            if (len_x[33:32] != 2'd0) begin
              ph_d = PhErr; ecode_d = StGammaOvf;
            end else begin
              copy_d = len_x[31:0]; ret_d = PhTag1; ph_d = PhRead;
            end
          end
          PhShort: begin
            if (!hfull_q) begin
              rsp_d = mk(1'b0, 8'd0, 1'b1, 1'b0, StOk, cnt_q); seq_d = SResp;
            end else begin
              hfull_d = 1'b0; am_d = 1'b1;
              if (hold_q[7:1] == 7'd0) begin
                lastoff_d = 32'd0; done_d = 1'b1; ph_d = PhDone;
                rsp_d = mk(1'b0, 8'd0, 1'b0, 1'b1, StOk, cnt_q); seq_d = SResp;
              end else if ({{(FillW-7){1'b0}}, hold_q[7:1]} > fill_q) begin
                ph_d = PhErr; ecode_d = StBadOff;
              end else begin
                moff_d = {25'd0, hold_q[7:1]}; lastoff_d = {25'd0, hold_q[7:1]};
                copy_d = {30'd0, 1'b1, hold_q[0]}; ret_d = PhTag1; ph_d = PhRead;
              end
            end
          end
          PhOfflo: begin
            if (!hfull_q) begin
              rsp_d = mk(1'b0, 8'd0, 1'b1, 1'b0, StOk, cnt_q); seq_d = SResp;
            end else begin
              hfull_d = 1'b0;
              if (moff_q[31:24] != 8'd0 || off_full == 33'd0 ||
                  off_full > {{(33-FillW){1'b0}}, fill_q}) begin
                ph_d = PhErr; ecode_d = StBadOff;
              end else begin
                moff_d = off_full[31:0]; lastoff_d = off_full[31:0];
                gacc_d = 32'd1; ph_d = PhGlv;
              end
            end
          end
          PhRead: ph_d = PhCopy;  // address presented, data next cycle
          PhCopy: begin
            we = 1'b1; wdata = rdata;
            copy_d = copy_q - 32'd1;
            ph_d = (copy_q == 32'd1) ? ret_q : PhRead;
            seq_d = SResp;
            rsp_d = mk(1'b1, rdata, 1'b0, 1'b0, StOk, cnt_q + 32'd1);
          end
          PhErr: begin
            err_d = 1'b1; ph_d = PhTag1;
            rsp_d = mk(1'b0, 8'd0, 1'b0, 1'b0, ecode_q, cnt_q); seq_d = SResp;
          end
          default: begin
            done_d = 1'b1; ph_d = PhDone;
            rsp_d = mk(1'b0, 8'd0, 1'b0, 1'b1, StOk, cnt_q); seq_d = SResp;
          end
        endcase
        if (we) begin
          wpos_d = wpos_q + AddrW'(1);
          if (fill_q != FillW'(WindowSize)) fill_d = fill_q + FillW'(1);
          cnt_d = cnt_q + 32'd1;
          if (ph_q != PhCopy) begin
            rsp_d = mk(1'b1, wdata, 1'b0, 1'b0, StOk, cnt_q + 32'd1);
            seq_d = SResp;
          end
        end
      end
      SResp: if (!out_stall_i) seq_d = SIdle;
      default: seq_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SIdle; ph_q <= PhFirst; ret_q <= PhTag1;
      hold_q <= '0; tag_q <= '0; hfull_q <= 1'b0; am_q <= 1'b0;
      done_q <= 1'b0; err_q <= 1'b0; tleft_q <= '0; lastoff_q <= NoOffset;
      gacc_q <= 32'd1; moff_q <= '0; copy_q <= '0; cnt_q <= '0;
      ecode_q <= StOk; fill_q <= '0; wpos_q <= '0;
    end else begin
      seq_q <= seq_d; ph_q <= ph_d; ret_q <= ret_d;
      hold_q <= hold_d; tag_q <= tag_d; hfull_q <= hfull_d; am_q <= am_d;
      done_q <= done_d; err_q <= err_d; tleft_q <= tleft_d;
      lastoff_q <= lastoff_d; gacc_q <= gacc_d; moff_q <= moff_d;
      copy_q <= copy_d; cnt_q <= cnt_d; ecode_q <= ecode_d;
      fill_q <= fill_d; wpos_q <= wpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // a result is only offered while requests are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("response while request side open");
  // history fill never exceeds the window
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillW'(WindowSize))
    else $error("fill count overflow");
  // byte count moves only together with a history write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(we))
    else $error("count moved without output byte");

endmodule
